>>> rtl/fir_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the direct-form FIR filter.
// No dependencies; every other rtl file but fir_queue refers to it by scoped names.
package fir_pkg;

	// Command field of an input item
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Decoded operation handed from the front end to the MAC engine
	localparam logic [1:0] OP_NOP    = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	// Configuration register word index (byte address / 4)
	localparam logic REG_TAPS_IN_USE = 1'b0;
	localparam logic [6:0] TAPS_IN_USE_RESET = 7'd64;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         coef_index;
		logic signed [15:0] coef_value;
		logic signed [15:0] sample_in;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               clipped;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         index;
		logic signed [15:0] data;
	} op_t;

endpackage

>>> rtl/fir_queue.sv
`timescale 1ns / 1ps
// Small register FIFO used between front end, MAC engine and result port.
// Depends on nothing.
module fir_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slots_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/fir_apb_regs.sv
`timescale 1ns / 1ps
// APB register file: holds the taps_in_use setting.
// Depends on fir_pkg.
module fir_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [6:0]  taps_in_use
);

	logic [6:0] taps_q;
	logic       sel_taps;

	assign sel_taps    = (paddr[2] == fir_pkg::REG_TAPS_IN_USE);
	assign taps_in_use = taps_q;
	assign prdata      = sel_taps ? {25'd0, taps_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= fir_pkg::TAPS_IN_USE_RESET;
		end else if (psel && penable && pwrite && sel_taps) begin
			taps_q <= pwdata[6:0];
		end
	end

endmodule

>>> rtl/fir_front.sv
`timescale 1ns / 1ps
// Front end: takes input requests, decodes them into operations, queues them.
// Depends on fir_pkg and fir_queue.
module fir_front #(
	parameter int TAPS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fir_pkg::in_item_t   item,
	input  logic                hold,
	output logic                full,
	input  logic                op_pop,
	output fir_pkg::op_t        op,
	output logic                op_empty
);

	localparam logic [8:0] TAPS9 = 9'(TAPS);

	fir_pkg::op_t op_in;
	logic         q_full;

	// loads past the end of the store are dropped here as no-ops
	always_comb begin
		op_in.index = item.coef_index;
		if (item.cmd == fir_pkg::CMD_SAMPLE) begin
			op_in.kind = fir_pkg::OP_SAMPLE;
			op_in.data = item.sample_in;
		end else begin
			op_in.kind = ({3'b000, item.coef_index} < TAPS9) ? fir_pkg::OP_LOAD
			                                                 : fir_pkg::OP_NOP;
			op_in.data = item.coef_value;
		end
	end

	assign full = q_full || hold;

	fir_queue #(
		.W     ($bits(fir_pkg::op_t)),
		.DEPTH (2)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full),
		.wdata  (op_in),
		.full   (q_full),
		.pop    (op_pop),
		.rdata  (op),
		.empty  (op_empty)
	);

endmodule

>>> rtl/fir_back.sv
`timescale 1ns / 1ps
// MAC engine: coefficient and delay-line memories, one multiply-accumulate per tap.
// Depends on fir_pkg.
module fir_back #(
	parameter int TAPS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [6:0]           taps_in_use,
	input  fir_pkg::op_t         op,
	input  logic                 op_empty,
	output logic                 op_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output fir_pkg::out_item_t   res,
	output logic                 clearing
);

	localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int ACC_W = 33 + AW;
	localparam int QW    = ACC_W - 15;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
	localparam logic [8:0]    TAPS9     = 9'(TAPS);
	localparam logic signed [QW-1:0] QMAX = QW'(32767);
	localparam logic signed [QW-1:0] QMIN = QW'(-32768);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic signed [15:0] coef_mem [TAPS];
	logic signed [15:0] dly_mem  [TAPS];

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q, head_q, ptr_q, k_q, last_q;
	logic [AW-1:0] head_nxt, last_tap;
	logic [8:0]    t9;

	logic          coef_we, dly_we, issue;
	logic [AW-1:0] coef_wa, dly_wa;
	logic signed [15:0] coef_wd, dly_wd;

	logic               v_s1, first_s1, last_s1;
	logic signed [15:0] coef_s1, samp_s1;
	logic               v_s2, first_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [QW-1:0] q;
	logic                 adj;

	assign clearing = (state_q == S_CLEAR);
	assign head_nxt = (head_q == LAST_ADDR) ? '0 : head_q + 1'b1;

	// taps_in_use clamped to 1..TAPS, held as index of the last tap
	assign t9 = {2'b00, taps_in_use};
	always_comb begin
		if (t9 == 9'd0)      last_tap = '0;
		else if (t9 > TAPS9) last_tap = LAST_ADDR;
		else                 last_tap = AW'(t9 - 9'd1);
	end

	always_comb begin
		coef_we = 1'b0;
		dly_we  = 1'b0;
		coef_wa = AW'(op.index);
		dly_wa  = head_nxt;
		coef_wd = op.data;
		dly_wd  = op.data;
		op_pop  = 1'b0;
		if (state_q == S_CLEAR) begin
			coef_we = 1'b1;
			dly_we  = 1'b1;
			coef_wa = clr_q;
			dly_wa  = clr_q;
			coef_wd = '0;
			dly_wd  = '0;
		end else if (state_q == S_IDLE && !op_empty) begin
			op_pop  = 1'b1;
			coef_we = (op.kind == fir_pkg::OP_LOAD);
			dly_we  = (op.kind == fir_pkg::OP_SAMPLE);
		end
	end

	assign issue = (state_q == S_RUN);

	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[coef_wa] <= coef_wd;
		if (dly_we)  dly_mem[dly_wa]   <= dly_wd;
		if (issue) begin
			coef_s1 <= coef_mem[k_q];
			samp_s1 <= dly_mem[ptr_q];
		end
		prod_s2 <= coef_s1 * samp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			head_q   <= '0;
			ptr_q    <= '0;
			k_q      <= '0;
			last_q   <= '0;
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			acc_q    <= '0;
		end else begin
			v_s1     <= issue;
			first_s1 <= issue && (k_q == '0);
			last_s1  <= issue && (k_q == last_q);
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (v_s2) acc_q <= (first_s2 ? '0 : acc_q) + ACC_W'(prod_s2);

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!op_empty && op.kind == fir_pkg::OP_SAMPLE) begin
						head_q  <= head_nxt;
						ptr_q   <= head_nxt;
						k_q     <= '0;
						last_q  <= last_tap;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					k_q   <= k_q + 1'b1;
					ptr_q <= (ptr_q == '0) ? LAST_ADDR : ptr_q - 1'b1;
					if (k_q == last_q) state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (v_s2 && last_s2) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divide by 2^15 truncating toward zero, then saturate
	assign adj = acc_q[ACC_W-1] && (acc_q[14:0] != 15'd0);
	assign q   = $signed(acc_q[ACC_W-1:15]) + $signed({{(QW-1){1'b0}}, adj});

	always_comb begin
		if (q > QMAX) begin
			res.sample_out = 16'sh7fff;
			res.clipped    = 1'b1;
		end else if (q < QMIN) begin
			res.sample_out = 16'sh8000;
			res.clipped    = 1'b1;
		end else begin
			res.sample_out = q[15:0];
			res.clipped    = 1'b0;
		end
	end

	assign res_push = (state_q == S_DONE) && !res_full;

endmodule

>>> rtl/fir_filter_direct_form_core.sv
`timescale 1ns / 1ps
// Direct-form FIR filter, top level. Depends on fir_pkg, fir_apb_regs,
// fir_front, fir_back and fir_queue.
// Samples are filtered one at a time by the single multiply-accumulate unit over the n taps
// in use (n = 1..TAPS); the next sample starts once the last result is in the result queue.
// A coefficient load is written in the engine's idle state. Reset: asynchronous, active low,
// then a clearing pass over every address of both memories, full high.
module fir_filter_direct_form_core #(
	parameter int TAPS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration (APB)
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// input requests
	input  logic                push,
	output logic                full,
	input  fir_pkg::in_item_t   item,
	// results
	output logic                empty,
	input  logic                pop,
	output fir_pkg::out_item_t  result
);

	logic [6:0]          taps_in_use;
	fir_pkg::op_t        op;
	logic                op_empty, op_pop;
	logic                res_full, res_push;
	fir_pkg::out_item_t  res;
	logic                clearing;

	// no wait states on the register port
	assign pready = 1'b1;

	fir_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.taps_in_use (taps_in_use)
	);

	// Front end: decode each request (sample, coefficient load, or out-of-range
	// load dropped as a no-op) and queue it so the front need not wait on the MAC while the queue has room.
	fir_front #(
		.TAPS (TAPS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.hold     (clearing),
		.full     (full),
		.op_pop   (op_pop),
		.op       (op),
		.op_empty (op_empty)
	);

	// Back end: circular delay line plus coefficient memory, one tap per cycle
	// through a read / multiply / accumulate pipeline.
	fir_back #(
		.TAPS (TAPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.taps_in_use (taps_in_use),
		.op          (op),
		.op_empty    (op_empty),
		.op_pop      (op_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res),
		.clearing    (clearing)
	);

	// Result queue decouples the engine from a stalled consumer.
	fir_queue #(
		.W     ($bits(fir_pkg::out_item_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

>>> rtl/fir_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the FIR filter, bound to the top level.
// Depends on fir_pkg and fir_filter_direct_form_core.
module fir_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [2:0]          paddr,
	input logic [31:0]         pwdata,
	input logic [31:0]         prdata,
	input logic                empty,
	input logic                pop,
	input fir_pkg::out_item_t  result
);

	// a waiting result stays until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before pop");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("result changed while waiting");

	// saturation flag only with a rail value
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.clipped) |->
		(result.sample_out == 16'sh7fff || result.sample_out == 16'sh8000))
		else $error("clipped set on a non-rail value");

	// taps register reads back what was written
	a_taps_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == fir_pkg::REG_TAPS_IN_USE) |=>
		(paddr[2] != fir_pkg::REG_TAPS_IN_USE ||
		 prdata == {25'd0, $past(pwdata[6:0])}))
		else $error("taps_in_use readback mismatch");

endmodule

bind fir_filter_direct_form_core fir_checker u_fir_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.empty   (empty),
	.pop     (pop),
	.result  (result)
);

>>> tb/fir_checker.sv
`timescale 1ns / 1ps
// Checker for fir_filter_direct_form_core: predicts filtered samples and compares results.
// Depends on fir_pkg; watches the request, result and APB ports of the filter.
module fir_scoreboard #(
	parameter int TAPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               push,
	input  logic               full,
	input  fir_pkg::in_item_t  item,
	input  logic               empty,
	input  logic               pop,
	input  fir_pkg::out_item_t result,
	output int                 mismatch_count,
	output int                 pending
);
	import fir_pkg::*;

	localparam logic [2:0] TAPS_ADDR = {REG_TAPS_IN_USE, 2'b00};

	logic signed [15:0] delay_taps [TAPS];
	logic signed [15:0] coef_taps [TAPS];
	logic [6:0]         taps_cfg;
	out_item_t          filtered_q [$];

	assign pending = filtered_q.size();

	initial begin
		mismatch_count = 0;
		taps_cfg = TAPS_IN_USE_RESET;
		for (int k = 0; k < TAPS; k++) begin
			delay_taps[k] = '0;
			coef_taps[k] = '0;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns  checker: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		longint    acc;
		longint    quot;
		int        span;
		logic      clip;
		if (arst_n) begin
			// results first: a sample pushed this edge cannot be out yet
			if (pop && !empty) begin
				if (filtered_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result sample_out=%0d clipped=%0b",
						result.sample_out, result.clipped));
				end else begin
					want = filtered_q.pop_front();
					if (result.sample_out !== want.sample_out)
						report_mismatch($sformatf("sample_out got %0d expected %0d",
							result.sample_out, want.sample_out));
					if (result.clipped !== want.clipped)
						report_mismatch($sformatf("clipped got %0b expected %0b (sample_out %0d)",
							result.clipped, want.clipped, want.sample_out));
				end
			end

			if (push && !full) begin
				if (item.cmd == CMD_LOAD) begin
					if (int'(item.coef_index) < TAPS)
						coef_taps[item.coef_index] = item.coef_value;
				end else begin
					// whole line shifts regardless of taps in use
					for (int k = TAPS - 1; k > 0; k--)
						delay_taps[k] = delay_taps[k - 1];
					delay_taps[0] = item.sample_in;

					span = int'(taps_cfg);
					if (span == 0)
						span = 1;
					if (span > TAPS)
						span = TAPS;

					acc = 0;
					for (int k = 0; k < span; k++)
						acc += longint'(delay_taps[k]) * longint'(coef_taps[k]);

					// Q.15 sum -> integer, truncating toward zero
					quot = acc / 64'sd32768;
					clip = 1'b0;
					if (quot > 32767) begin
						quot = 32767;
						clip = 1'b1;
					end else if (quot < -32768) begin
						quot = -32768;
						clip = 1'b1;
					end
					want.sample_out = quot[15:0];
					want.clipped = clip;
					filtered_q.insert(filtered_q.size(), want);
				end
			end

			if (psel && penable && pwrite && pready && paddr == TAPS_ADDR)
				taps_cfg = pwdata[6:0];
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the FIR filter testbench: clock, reset, requests, taps settings and verdict.
// Depends on fir_pkg, fir_filter_direct_form_core and fir_scoreboard.
module tb_top;
	import fir_pkg::*;

	localparam int TAPS = 64;
	localparam logic [2:0] TAPS_ADDR = {REG_TAPS_IN_USE, 2'b00};
	// Quiet time after the last result before touching config or ending:
	// covers a backlog of coefficient loads still inside the engine.
	localparam int DRAIN_CYCLES = 2 * TAPS + 16;
	// Cycles with no request or result accepted before giving up. The long
	// receiver hold-off is the worst correct case, well below this.
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 4000;
	localparam int HOLD_AFTER_RESULTS = 300;
	localparam int PHASE_REQUESTS = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       psel = 1'b0;
	logic       penable = 1'b0;
	logic       pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic       pready;
	logic       push = 1'b0;
	logic       full;
	in_item_t   item = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_item_t  result;

	int mismatch_count;
	int pending;

	// sender pacing state
	int burst_left = 0;

	always #6 clk = ~clk;

	fir_filter_direct_form_core #(.TAPS(TAPS)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	fir_scoreboard #(.TAPS(TAPS)) u_scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.push           (push),
		.full           (full),
		.item           (item),
		.empty          (empty),
		.pop            (pop),
		.result         (result),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// Mostly uniform 16-bit words, with a good share of the extremes and
	// values around zero so saturation and sign handling get exercised.
	function automatic logic signed [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: pick_word = 16'sh7FFF;
			1: pick_word = 16'sh8000;
			2: pick_word = 16'($signed($urandom_range(0, 2)) - 1);
			default: pick_word = 16'($urandom);
		endcase
	endfunction

	// Sample field is noise on a load; it must be ignored.
	function automatic in_item_t coef_load(input logic [5:0] idx,
			input logic signed [15:0] val);
		coef_load.cmd = CMD_LOAD;
		coef_load.coef_index = idx;
		coef_load.coef_value = val;
		coef_load.sample_in = 16'($urandom);
	endfunction

	// Coefficient fields are noise on a sample; they must be ignored.
	function automatic in_item_t new_sample(input logic signed [15:0] s);
		new_sample.cmd = CMD_SAMPLE;
		new_sample.coef_index = 6'($urandom);
		new_sample.coef_value = 16'($urandom);
		new_sample.sample_in = s;
	endfunction

	// Offer one request and wait until it is taken. Bursts of random length
	// are separated by random gaps; some bursts run with no gap at all.
	task automatic send_request(input in_item_t req);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk) push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 24);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= req;
		do @(posedge clk); while (full);
		burst_left--;
	endtask

	// Stop offering, wait for every predicted result, then let any trailing
	// coefficient loads clear the engine.
	task automatic wait_idle();
		@(negedge clk) push <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_taps(input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TAPS_ADDR;
		pwdata <= 32'(value);
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Receiver: pop pattern changes mode every so often (always ready, light
	// or heavy stalls). Once, after enough results and while the sender is
	// offering, it holds off long enough for the block to back up.
	initial begin
		int mode_left;
		int stall_pct;
		int popped;
		bit held;
		mode_left = 0;
		stall_pct = 0;
		popped = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && popped >= HOLD_AFTER_RESULTS && push) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 70;
					default: stall_pct = 95;
				endcase
			end
			mode_left--;
			pop <= ($urandom_range(0, 99) >= stall_pct);
			@(posedge clk);
			if (pop && !empty)
				popped++;
		end
	end

	// Watchdog: ends the run if nothing moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top failed");
		$finish;
	end

	// Stimulus
	initial begin
		int taps_plan [$] = '{0, 1, 127, 65, 64, 2, 9, 40};
		int sent;
		int pick;
		int base;
		logic signed [15:0] fill;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset taps count: zero coefficients first,
		// then extreme coefficients at both ends of the store, then runs of
		// extreme samples that saturate high and low.
		send_request(new_sample(16'sh7FFF));
		send_request(new_sample(16'sh8000));
		send_request(coef_load(6'd0, 16'sh7FFF));
		send_request(coef_load(6'd63, 16'sh8000));
		send_request(coef_load(6'd1, 16'sh8000));
		send_request(coef_load(6'd2, 16'sh8000));
		send_request(coef_load(6'd3, 16'sh8000));
		send_request(new_sample(16'sh8000));
		send_request(new_sample(16'sh8000));
		send_request(new_sample(16'sh8000));
		send_request(new_sample(16'sh8000));
		send_request(new_sample(16'sh7FFF));
		send_request(new_sample(16'sh7FFF));
		send_request(new_sample(16'sh7FFF));
		send_request(new_sample(16'sh7FFF));
		send_request(new_sample(16'sh0000));
		send_request(new_sample(-16'sd1));
		send_request(new_sample(16'sd1));
		send_request(coef_load(6'd0, 16'sh0000));
		send_request(coef_load(6'd62, 16'sh7FFF));
		send_request(new_sample(16'sh8000));

		// Random phases, each under its own taps count: zero and over-range
		// counts, the full line, and a random one at the end.
		taps_plan.insert(taps_plan.size(), int'($urandom_range(3, 126)));
		foreach (taps_plan[p]) begin
			wait_idle();
			write_taps(taps_plan[p]);
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					// reload a run of taps with one large value to drive the sum
					// into saturation
					base = $urandom_range(0, TAPS - 1);
					fill = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
					for (int k = 0; k < 8; k++)
						send_request(coef_load(6'(base + k), fill));
					sent += 8;
				end else if (pick < 38) begin
					send_request(coef_load(6'($urandom), pick_word()));
					sent++;
				end else begin
					send_request(new_sample(pick_word()));
					sent++;
				end
			end
		end

		wait_idle();
		if (mismatch_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
